>>> sv/fbpa_pkg.sv
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned BYTES_W    = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned ALIGN_W    = 8;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(ADDR_W);

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_SIZE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_ALIGN  = CFG_IDX_W'(3);

  localparam logic [SIZE_W-1:0]  OBJ_SIZE_RST  = SIZE_W'(8);
  localparam logic [ALIGN_W-1:0] OBJ_ALIGN_RST = ALIGN_W'(8);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_INIT_DIV,
    S_LINK,
    S_IDLE,
    S_DECODE,
    S_ALLOC_WB,
    S_FREE_DIV,
    S_FREE_WB
  } state_e;

  typedef enum logic [1:0] {
    COMMIT_NONE,
    COMMIT_ALLOC,
    COMMIT_FREE,
    COMMIT_REJECT
  } commit_e;

  typedef struct packed {
    req_kind_e            req_type;
    logic [SIZE_W-1:0]    req_size;
    logic [ALIGN_W-1:0]   req_align;
    logic [ADDR_W-1:0]    free_addr;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [ADDR_W-1:0]    block_addr;
    logic [BYTES_W-1:0]   used_bytes;
    logic [COUNT_W-1:0]   alloc_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    init_begin;
    logic    div_start;
    logic    div_free;
    logic    total_load;
    logic    link_step;
    logic    head_init;
    logic    req_load;
    logic    alloc_read;
    commit_e commit;
    status_e reject_code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cfg_hit;
    logic init_short;
    logic div_done;
    logic total_zero;
    logic walk_last;
    logic req_is_free;
    logic alloc_mismatch;
    logic pool_empty;
    logic free_pre_bad;
    logic free_bad;
  } sts_t;

endpackage

>>> sv/fbpa_stream_if.sv
`timescale 1ns / 1ps

interface fbpa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/fbpa_div.sv
`timescale 1ns / 1ps

// radix-2 restoring divider, one quotient bit per cycle
module fbpa_div import fbpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ADDR_W-1:0] dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [ADDR_W-1:0] quot_o,
  output logic [SIZE_W-1:0] rem_o
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(ADDR_W - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [ADDR_W-1:0]    quo_q;
  logic [SIZE_W-1:0]    rem_q;
  logic [SIZE_W-1:0]    dvs_q;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[ADDR_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + DIV_CNT_W'(1);
      busy_q <= (cnt_q != LAST_STEP);
      done_q <= (cnt_q == LAST_STEP);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[ADDR_W-2:0], fits};
      rem_q <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> sv/fbpa_ctrl.sv
`timescale 1ns / 1ps

module fbpa_ctrl import fbpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  input  logic req_valid_i,
  input  logic rsp_ready_i,
  output cmd_t cmd_o,
  output logic req_ready_o,
  output logic rsp_valid_o
);

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   out_free;

  // result register can take a new transaction this cycle
  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        state_d = sts_i.init_short ? S_IDLE : S_INIT_DIV;
      end
      S_INIT_DIV: begin
        if (sts_i.div_done) state_d = S_LINK;
      end
      S_LINK: begin
        if (sts_i.total_zero || sts_i.walk_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.req_is_free) begin
          if (!sts_i.free_pre_bad) begin
            state_d = S_FREE_DIV;
          end else if (out_free) begin
            state_d = S_IDLE;
          end
        end else if (sts_i.alloc_mismatch || sts_i.pool_empty) begin
          if (out_free) state_d = S_IDLE;
        end else begin
          state_d = S_ALLOC_WB;
        end
      end
      S_ALLOC_WB: begin
        if (out_free) state_d = S_IDLE;
      end
      S_FREE_DIV: begin
        if (sts_i.div_done) state_d = S_FREE_WB;
      end
      S_FREE_WB: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
    // any write to a mapped register rebuilds the pool
    if (sts_i.cfg_hit) state_d = S_INIT;
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.commit      = COMMIT_NONE;
    cmd_o.reject_code = ST_OK;
    req_ready_o       = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.init_begin = 1'b1;
        cmd_o.div_start  = !sts_i.init_short;
      end
      S_INIT_DIV: begin
        cmd_o.total_load = sts_i.div_done;
      end
      S_LINK: begin
        cmd_o.link_step = !sts_i.total_zero;
        cmd_o.head_init = !sts_i.total_zero && sts_i.walk_last;
      end
      S_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.req_load = req_valid_i;
      end
      S_DECODE: begin
        if (sts_i.req_is_free) begin
          if (!sts_i.free_pre_bad) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_free  = 1'b1;
          end else if (out_free) begin
            cmd_o.commit      = COMMIT_REJECT;
            cmd_o.reject_code = ST_BAD_FREE;
          end
        end else if (sts_i.alloc_mismatch) begin
          if (out_free) begin
            cmd_o.commit      = COMMIT_REJECT;
            cmd_o.reject_code = ST_MISMATCH;
          end
        end else if (sts_i.pool_empty) begin
          if (out_free) begin
            cmd_o.commit      = COMMIT_REJECT;
            cmd_o.reject_code = ST_EMPTY;
          end
        end else begin
          cmd_o.alloc_read = 1'b1;
        end
      end
      S_ALLOC_WB: begin
        if (out_free) cmd_o.commit = COMMIT_ALLOC;
      end
      S_FREE_DIV: begin
      end
      S_FREE_WB: begin
        if (out_free) begin
          if (sts_i.free_bad) begin
            cmd_o.commit      = COMMIT_REJECT;
            cmd_o.reject_code = ST_BAD_FREE;
          end else begin
            cmd_o.commit = COMMIT_FREE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.commit != COMMIT_NONE) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

>>> sv/fbpa_dp.sv
`timescale 1ns / 1ps

module fbpa_dp import fbpa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  req_t                  req_data_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output rsp_t                  rsp_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned MEM_AW = $clog2(MAX_BLOCKS);
  localparam int unsigned PROD_W = IDX_W + SIZE_W;
  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(MAX_BLOCKS);

  // highest power of two not above a, at least 1, minus one
  function automatic logic [ALIGN_W-1:0] align_mask(input logic [ALIGN_W-1:0] a);
    logic [ALIGN_W-1:0] p;
    p = ALIGN_W'(1);
    for (int b = 1; b < ALIGN_W; b++) begin
      if (a[b]) p = ALIGN_W'(1) << b;
    end
    return p - ALIGN_W'(1);
  endfunction

  logic [ADDR_W-1:0]  pool_base_q;
  logic [BYTES_W-1:0] pool_bytes_q;
  logic [SIZE_W-1:0]  object_size_q;
  logic [ALIGN_W-1:0] object_align_q;

  logic [ADDR_W-1:0]  aligned_start_q;
  logic [IDX_W-1:0]   total_q;
  logic [IDX_W-1:0]   head_q;
  logic [IDX_W-1:0]   walk_q;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [ADDR_W-1:0]  blocks_q, blocks_d;

  req_t               req_q;
  rsp_t               rsp_q;
  logic [ADDR_W-1:0]  prod_q;
  logic [PROD_W-1:0]  prod_full;
  logic [IDX_W-1:0]   link_rd_q;

  logic               cfg_hit;
  logic [ADDR_W-1:0]  adj;
  logic [BYTES_W-1:0] size_ext;
  logic [ADDR_W-1:0]  div_dividend;
  logic               div_done;
  logic [ADDR_W-1:0]  div_quot;
  logic [SIZE_W-1:0]  div_rem;
  logic [IDX_W-1:0]   quot_sat;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   walk_nxt;
  logic [IDX_W-1:0]   link_val;

  logic               mem_we;
  logic [MEM_AW-1:0]  mem_waddr;
  logic [IDX_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]   link_mem [MAX_BLOCKS];

  // register file
  always_comb begin
    case (cfg_idx_i)
      CFG_POOL_BASE, CFG_POOL_BYTES, CFG_OBJ_SIZE, CFG_OBJ_ALIGN: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q    <= '0;
      pool_bytes_q   <= '0;
      object_size_q  <= OBJ_SIZE_RST;
      object_align_q <= OBJ_ALIGN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_BASE:  pool_base_q    <= cfg_data_i;
        CFG_POOL_BYTES: pool_bytes_q   <= cfg_data_i;
        CFG_OBJ_SIZE:   object_size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_OBJ_ALIGN:  object_align_q <= cfg_data_i[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  assign adj      = (ADDR_W'(0) - pool_base_q) & ADDR_W'(align_mask(object_align_q));
  assign size_ext = BYTES_W'(object_size_q);

  // shared divider: block count at init, address to index on free
  assign div_dividend = cmd_i.div_free ? (req_q.free_addr - aligned_start_q)
                                       : (pool_bytes_q - adj);

  fbpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (object_size_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign quot_sat = (div_quot > ADDR_W'(MAX_BLOCKS)) ? NULL_IDX : div_quot[IDX_W-1:0];
  assign free_idx = div_quot[IDX_W-1:0];

  assign walk_nxt = walk_q + IDX_W'(1);
  assign link_val = (walk_nxt < total_q) ? walk_nxt : NULL_IDX;

  always_comb begin
    bytes_d  = bytes_q;
    blocks_d = blocks_q;
    case (cmd_i.commit)
      COMMIT_ALLOC: begin
        bytes_d  = bytes_q + size_ext;
        blocks_d = blocks_q + ADDR_W'(1);
      end
      COMMIT_FREE: begin
        bytes_d  = bytes_q - size_ext;
        blocks_d = blocks_q - ADDR_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aligned_start_q <= '0;
      total_q         <= '0;
      head_q          <= NULL_IDX;
      walk_q          <= '0;
      bytes_q         <= '0;
      blocks_q        <= '0;
    end else begin
      if (cmd_i.init_begin) begin
        aligned_start_q <= pool_base_q + adj;
        total_q         <= '0;
        head_q          <= NULL_IDX;
        walk_q          <= '0;
        bytes_q         <= '0;
        blocks_q        <= '0;
      end else begin
        bytes_q  <= bytes_d;
        blocks_q <= blocks_d;
      end
      if (cmd_i.total_load) total_q <= quot_sat;
      if (cmd_i.link_step) walk_q <= walk_nxt;
      if (cmd_i.head_init) head_q <= '0;
      case (cmd_i.commit)
        COMMIT_ALLOC: head_q <= link_rd_q;
        COMMIT_FREE:  head_q <= free_idx;
        default: ;
      endcase
    end
  end

  // successor list, one write and one registered read per cycle
  assign mem_we    = cmd_i.link_step || (cmd_i.commit == COMMIT_FREE);
  assign mem_waddr = cmd_i.link_step ? walk_q[MEM_AW-1:0] : free_idx[MEM_AW-1:0];
  assign mem_wdata = cmd_i.link_step ? link_val : head_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (cmd_i.alloc_read) link_rd_q <= link_mem[head_q[MEM_AW-1:0]];
  end

  assign prod_full = PROD_W'(head_q) * PROD_W'(object_size_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) req_q <= req_data_i;
    if (cmd_i.alloc_read) prod_q <= ADDR_W'(prod_full);
    if (cmd_i.commit != COMMIT_NONE) begin
      rsp_q.status      <= (cmd_i.commit == COMMIT_REJECT) ? cmd_i.reject_code : ST_OK;
      rsp_q.block_addr  <= (cmd_i.commit == COMMIT_ALLOC) ? (aligned_start_q + prod_q) : '0;
      rsp_q.used_bytes  <= bytes_d;
      rsp_q.alloc_count <= blocks_d[COUNT_W-1:0];
    end
  end

  assign sts_o.cfg_hit        = cfg_hit;
  assign sts_o.init_short     = (object_size_q == '0) || (pool_bytes_q < adj);
  assign sts_o.div_done       = div_done;
  assign sts_o.total_zero     = (total_q == '0);
  assign sts_o.walk_last      = (walk_nxt == total_q);
  assign sts_o.req_is_free    = (req_q.req_type == REQ_FREE);
  assign sts_o.alloc_mismatch = (req_q.req_size != object_size_q) ||
                                (req_q.req_align != object_align_q);
  assign sts_o.pool_empty     = (head_q >= total_q);
  assign sts_o.free_pre_bad   = (object_size_q == '0) || (blocks_q == '0);
  assign sts_o.free_bad       = (div_rem != '0) || (div_quot >= ADDR_W'(total_q));

  assign rsp_o = rsp_q;

endmodule

>>> sv/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps

// Fixed-size block pool allocator with a LIFO free list. The pool base is
// rounded up to a multiple of the largest power of two not above the block
// alignment, the pool is cut into as many blocks of object_size bytes as
// fit (at most MAX_BLOCKS), and the blocks are chained in ascending order.
// After reset and after every write to a mapped register the block rebuilds
// the pool and holds req ready low: a setup step, the serial divider for the
// block count, then one successor-list write per block (none for a pool of
// zero blocks, and only the setup step when object_size is zero or the pool
// is shorter than the alignment pad). An allocate pops the list head and
// returns its address: the request is accepted in idle, a decode step reads
// the head's successor and forms the block offset, and a writeback step adds
// the pool start. A free turns the address back into a block index through
// the same one-bit-per-cycle divider. Rejected requests (size or alignment
// mismatch, empty pool, a free with zero allocations or a zero object size)
// finish in the decode step; a free off a block boundary or past the last
// block is rejected after the divide. The result sits in an output
// register, so a new request is taken while the previous result still
// waits on rsp. Freeing a block that is already free is not caught and
// can corrupt the list.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fbpa_stream_if.sink           req_i,
  fbpa_stream_if.source         rsp_o
);

  cmd_t cmd;
  sts_t sts;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp_data;

  // sequencing: init walk, request decode, divider wait, writeback
  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sts_i       (sts),
    .req_valid_i (req_i.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid)
  );

  // registers, pool state, successor memory, divider and address math
  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_data_i (req_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_data)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

endmodule

>>> verif/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int unsigned POOL_DEPTH      = 1024;
  // run limit with wide margin over the slowest legal run
  localparam int unsigned RUN_LIMIT       = 1_000_000;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned PHASE_ITEMS     = 92;
  localparam int unsigned RSP_HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 40;
  // index past the register map; a write there must not rebuild the pool
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(9);

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fbpa_stream_if #(.payload_t(req_t)) req_if ();
  fbpa_stream_if #(.payload_t(rsp_t)) rsp_if ();

  fixed_block_pool_allocator #(
    .MAX_BLOCKS(POOL_DEPTH)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  // Shadow of the allocator: registers, free list and usage counters.
  // take_request() predicts the response of an accepted request and queues
  // it; match_result() compares each delivered response with the oldest one.
  class pool_shadow;
    logic [31:0] base_reg;
    logic [31:0] bytes_reg;
    logic [15:0] obj_size;
    logic [7:0]  obj_align;
    int unsigned links[POOL_DEPTH];
    int unsigned head;
    int unsigned total;
    logic [31:0] first_block;
    logic [31:0] bytes_used;
    logic [31:0] blocks_used;
    rsp_t        due_rsp[$];
    int unsigned errors;

    function new();
      base_reg  = '0;
      bytes_reg = '0;
      obj_size  = OBJ_SIZE_RST;
      obj_align = OBJ_ALIGN_RST;
      errors    = 0;
      rebuild();
    endfunction

    // bytes needed to round base up; a non-power-of-two alignment rounds down
    // to a power of two, zero counts as one, and the step is capped at 128
    function logic [31:0] pad_for(logic [31:0] base, logic [7:0] align);
      logic [31:0] step;
      step = 32'd1;
      while (step <= 32'd64 && (step << 1) <= {24'd0, align})
        step = step << 1;
      return (32'd0 - base) & (step - 32'd1);
    endfunction

    function void rebuild();
      logic [31:0] pad;
      logic [31:0] n;
      pad         = pad_for(base_reg, obj_align);
      first_block = base_reg + pad;
      if (obj_size == 16'd0 || bytes_reg < pad) begin
        total = 0;
      end else begin
        n     = (bytes_reg - pad) / obj_size;
        total = (n > POOL_DEPTH) ? POOL_DEPTH : n;
      end
      for (int unsigned i = 0; i < POOL_DEPTH; i++)
        links[i] = (i + 1 < total) ? i + 1 : POOL_DEPTH;
      head        = (total > 0) ? 0 : POOL_DEPTH;
      bytes_used  = '0;
      blocks_used = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        CFG_POOL_BASE:  base_reg  = value;
        CFG_POOL_BYTES: bytes_reg = value;
        CFG_OBJ_SIZE:   obj_size  = value[15:0];
        CFG_OBJ_ALIGN:  obj_align = value[7:0];
        default:        return;
      endcase
      rebuild();
    endfunction

    function rsp_t take_request(req_t r);
      rsp_t        e;
      logic [31:0] off;
      logic [31:0] idx;
      e.status     = ST_OK;
      e.block_addr = '0;
      if (r.req_type == REQ_ALLOC) begin
        // mismatch wins over an empty list
        if (r.req_size != obj_size || r.req_align != obj_align) begin
          e.status = ST_MISMATCH;
        end else if (head >= total) begin
          e.status = ST_EMPTY;
        end else begin
          idx          = head;
          e.block_addr = first_block + idx * obj_size;
          head         = links[idx];
          bytes_used   = bytes_used + obj_size;
          blocks_used  = blocks_used + 32'd1;
        end
      end else begin
        off = r.free_addr - first_block;
        if (obj_size == 16'd0 || blocks_used == 32'd0 || (off % obj_size) != 32'd0) begin
          e.status = ST_BAD_FREE;
        end else begin
          idx = off / obj_size;
          if (idx >= total) begin
            e.status = ST_BAD_FREE;
          end else begin
            // a block already on the list is pushed again, as the RTL does
            links[idx]  = head;
            head        = idx;
            bytes_used  = bytes_used - obj_size;
            blocks_used = blocks_used - 32'd1;
          end
        end
      end
      e.used_bytes  = bytes_used;
      e.alloc_count = blocks_used[COUNT_W-1:0];
      due_rsp.push_back(e);
      return e;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task match_result(rsp_t got);
      rsp_t want;
      if (due_rsp.size() == 0) begin
        report($sformatf("response with nothing outstanding: %p", got));
        return;
      end
      want = due_rsp.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.block_addr !== want.block_addr)
        report($sformatf("block_addr got %h want %h", got.block_addr, want.block_addr));
      if (got.used_bytes !== want.used_bytes)
        report($sformatf("used_bytes got %h want %h", got.used_bytes, want.used_bytes));
      if (got.alloc_count !== want.alloc_count)
        report($sformatf("alloc_count got %0d want %0d", got.alloc_count, want.alloc_count));
    endtask
  endclass

  pool_shadow  shadow = new();

  bit          quiet;          // phase without gaps on either side
  bit          rsp_hold_req;   // ask the response side for one long hold-off
  int unsigned cycle_count;
  logic [31:0] held_addrs[$];  // blocks handed out and not yet freed
  logic [31:0] freed_addrs[$]; // blocks already returned, for double frees

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("fixed_block_pool_allocator verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitors: both sample at the rising edge, before the DUT's updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : req_mon
    rsp_t e;
    if (rst_ni && req_if.valid && req_if.ready) begin
      e = shadow.take_request(req_if.data);
      if (req_if.data.req_type == REQ_ALLOC && e.status == ST_OK)
        held_addrs.push_back(e.block_addr);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      shadow.match_result(rsp_if.data);
  end

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned c;
    c = $urandom_range(0, 99);
    if (quiet || c < 60) return 0;
    if (c < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Response side: random back-pressure, plus one long hold-off on request
  // so the output register fills and the request side stalls.
  initial begin : rsp_sink
    int unsigned hold_left;
    int unsigned idle_left;
    hold_left    = 0;
    idle_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        hold_left    = RSP_HOLD_CYCLES;
      end
      if (!rst_ni) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (idle_left != 0) begin
        rsp_if.ready <= 1'b0;
        idle_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) idle_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request builders and drivers. Every driver task is entered and left just
  // after a falling edge.
  // ---------------------------------------------------------------------------
  function automatic req_t alloc_req(logic [15:0] size, logic [7:0] align);
    req_t r;
    r.req_type  = REQ_ALLOC;
    r.req_size  = size;
    r.req_align = align;
    r.free_addr = $urandom;
    return r;
  endfunction

  function automatic req_t free_req(logic [31:0] addr);
    req_t r;
    r.req_type  = REQ_FREE;
    r.req_size  = SIZE_W'($urandom);
    r.req_align = ALIGN_W'($urandom);
    r.free_addr = addr;
    return r;
  endfunction

  // Mostly legal traffic (matching allocs, frees of live blocks) with a tail
  // of rejects: wrong size/alignment, stray, misaligned, out-of-pool and
  // repeated frees.
  function automatic req_t random_req();
    int unsigned c;
    int unsigned k;
    logic [31:0] addr;
    c = $urandom_range(0, 99);
    if (c >= 45 && c < 80 && held_addrs.size() != 0) begin
      k    = $urandom_range(0, held_addrs.size() - 1);
      addr = held_addrs[k];
      held_addrs.delete(k);
      freed_addrs.push_back(addr);
      return free_req(addr);
    end
    if (c < 80) return alloc_req(shadow.obj_size, shadow.obj_align);
    if (c < 83) return alloc_req(SIZE_W'($urandom), shadow.obj_align);
    if (c < 86) return alloc_req(shadow.obj_size, ALIGN_W'($urandom));
    if (c < 89) return free_req($urandom);
    if (c < 93 && held_addrs.size() != 0) begin
      k = $urandom_range(0, held_addrs.size() - 1);
      return free_req(held_addrs[k] + $urandom_range(1, shadow.obj_size - 1));
    end
    if (c < 96) begin
      addr = shadow.first_block + shadow.total * shadow.obj_size;
      return free_req(addr + $urandom_range(0, 3) * shadow.obj_size);
    end
    if (freed_addrs.size() != 0)
      return free_req(freed_addrs[$urandom_range(0, freed_addrs.size() - 1)]);
    return free_req($urandom);
  endfunction

  // valid stays high across back-to-back transactions; it is only lowered
  // here for a gap or by drain_responses()
  task automatic send_request(req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_responses();
    req_if.valid <= 1'b0;
    while (shadow.due_rsp.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // A mapped write restarts the pool build; wait for ready to drop and
  // come back so the next write or request lands on an idle block.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    shadow.set_reg(idx, value);
    if (idx <= CFG_OBJ_ALIGN) begin
      do @(posedge clk_i); while (req_if.ready);
      do @(posedge clk_i); while (!req_if.ready);
      @(negedge clk_i);
    end
  endtask

  task automatic set_pool(logic [31:0] base, logic [31:0] bytes, logic [15:0] size,
                          logic [7:0] align);
    write_reg(CFG_POOL_BASE, base);
    write_reg(CFG_POOL_BYTES, bytes);
    write_reg(CFG_OBJ_SIZE, {16'd0, size});
    write_reg(CFG_OBJ_ALIGN, {24'd0, align});
    held_addrs.delete();
    freed_addrs.delete();
  endtask

  // Random pool geometry: mostly a handful of blocks so the list runs dry,
  // sometimes none, sometimes hundreds, now and then a saturated pool.
  task automatic pick_config(int unsigned phase, output logic [31:0] base,
                             output logic [31:0] bytes, output logic [15:0] size,
                             output logic [7:0] align);
    int unsigned     c;
    int unsigned     blocks;
    logic [31:0]     pad;
    longint unsigned span;
    c    = $urandom_range(0, 99);
    size = (c < 60) ? 16'($urandom_range(8, 64)) :
           (c < 85) ? 16'($urandom_range(8, 65535)) :
           (c < 93) ? 16'd65535 : 16'd8;
    c     = $urandom_range(0, 99);
    align = (c < 70) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom_range(1, 128));
    c    = $urandom_range(0, 99);
    base = (c < 45) ? $urandom :
           (c < 65) ? 32'd0 :
           (c < 85) ? 32'hFFFF_FFFF - $urandom_range(0, 4096) : 32'hFFFF_FFFF;
    if (phase == 0) begin
      base  = 32'd0;
      align = 8'd1;
      size  = 16'd8;
    end else if (phase == 1) begin
      base  = 32'hFFFF_FFFF;
      align = 8'd128;
      size  = 16'd65535;
    end
    pad = shadow.pad_for(base, align);
    c   = $urandom_range(0, 99);
    blocks = (c < 72) ? $urandom_range(1, 16) :
             (c < 82) ? 0 :
             (c < 92) ? $urandom_range(17, 200) : POOL_DEPTH + 50;
    span  = longint'(pad) + longint'(blocks) * size + $urandom_range(0, size - 1);
    bytes = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
    // short pool: smaller than the alignment pad
    if (blocks == 0 && pad != 0 && $urandom_range(0, 1) == 1)
      bytes = $urandom_range(0, pad - 1);
    if (c >= 97) bytes = 32'hFFFF_FFFF;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] base;
    logic [31:0] bytes;
    logic [15:0] size;
    logic [7:0]  align;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    quiet        = 1'b0;
    rsp_hold_req = 1'b0;
    cycle_count  = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // pool build after reset
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);

    // Reset geometry has no pool bytes: empty list, field extremes rejected,
    // free with nothing allocated.
    send_request(alloc_req(OBJ_SIZE_RST, OBJ_ALIGN_RST));
    send_request(alloc_req(16'd0, 8'd0));
    send_request(alloc_req(16'hFFFF, 8'hFF));
    send_request(free_req(32'd0));
    drain_responses();

    // unmapped register: ignored, no rebuild
    write_reg(CFG_UNMAPPED, $urandom);

    // Three 16-byte blocks from an unaligned base near the top of memory; the
    // last block address wraps through zero.
    set_pool(32'hFFFF_FFE3, 32'd56, 16'd16, 8'd8);
    send_request(alloc_req(16'd16, 8'd9));
    send_request(alloc_req(16'd17, 8'd8));
    repeat (3) send_request(alloc_req(16'd16, 8'd8));
    send_request(alloc_req(16'd16, 8'd8));
    send_request(free_req(32'hFFFF_FFF9));      // off a block boundary
    send_request(free_req(32'h0000_0018));      // one past the last block
    send_request(free_req(32'hFFFF_FFF8));
    send_request(free_req(32'hFFFF_FFF8));      // double free goes unnoticed
    repeat (2) send_request(alloc_req(16'd16, 8'd8));
    send_request(free_req(32'hFFFF_FFFF));
    drain_responses();

    // non-power-of-two alignment, largest objects, block count saturates
    set_pool(32'h1234_5678, 32'hFFFF_FFFF, 16'd65535, 8'd100);
    repeat (2) send_request(alloc_req(16'd65535, 8'd100));
    send_request(free_req(shadow.first_block + 32'd65535));
    drain_responses();

    // pad of 127 bytes against an empty pool
    set_pool(32'd1, 32'd0, 16'd8, 8'd128);
    send_request(alloc_req(16'd8, 8'd128));
    send_request(free_req(32'd128));
    drain_responses();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      pick_config(phase, base, bytes, size, align);
      set_pool(base, bytes, size, align);
      quiet = ($urandom_range(0, 3) == 0);
      // one long response stall while requests keep coming
      if (phase == 2) rsp_hold_req = 1'b1;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++)
        send_request(random_req());
      drain_responses();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shadow.due_rsp.size() != 0)
      shadow.report($sformatf("%0d responses never arrived", shadow.due_rsp.size()));
    if (shadow.errors == 0) begin
      $display("fixed_block_pool_allocator verification clean");
    end else begin
      $display("fixed_block_pool_allocator verification failed");
    end
    $finish;
  end

endmodule

>>> fixed_block_pool_allocator.f
sv/fbpa_pkg.sv
sv/fbpa_stream_if.sv
sv/fbpa_div.sv
sv/fbpa_ctrl.sv
sv/fbpa_dp.sv
sv/fixed_block_pool_allocator.sv
verif/fixed_block_pool_allocator_tb.sv
